>>> hw/rtl/trs_pkg.sv
package trs_pkg;

	localparam int CONNECTIONS = 8;
	localparam int CONN_W = 3;
	localparam int MAX_PAYLOAD = 1024;
	localparam int TIMEOUT_W = 18;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX = '1;
	localparam logic [15:0] BASE_TIMEOUT_RESET = 16'd30;
	localparam logic [3:0] MAX_RETRIES_RESET = 4'd3;
	localparam logic [3:0] RETRY_SAT = 4'd15;

	localparam logic [0:0] REG_BASE_TIMEOUT = 1'd0;
	localparam logic [0:0] REG_MAX_RETRIES = 1'd1;

	localparam logic [2:0] OP_TICK = 3'd0;
	localparam logic [2:0] OP_ARM_DATA = 3'd1;
	localparam logic [2:0] OP_ARM_FIN = 3'd2;
	localparam logic [2:0] OP_ACK = 3'd3;
	localparam logic [2:0] OP_ESTABLISH = 3'd4;

	localparam logic [2:0] ACT_DONE = 3'd0;
	localparam logic [2:0] ACT_ACCEPTED = 3'd1;
	localparam logic [2:0] ACT_REJECTED = 3'd2;
	localparam logic [2:0] ACT_RESEND_DATA = 3'd3;
	localparam logic [2:0] ACT_RESEND_FIN = 3'd4;
	localparam logic [2:0] ACT_ABORTED = 3'd5;
	localparam logic [2:0] ACT_ACKED = 3'd6;
	localparam logic [2:0] ACT_CLOSED = 3'd7;

	typedef enum logic [2:0] {
		CMD_TICK = 3'b001,
		CMD_ARM = 3'b010,
		CMD_ACK = 3'b100
	} cmd_kind_t;

	// classified command handed from front to back
	typedef struct packed {
		cmd_kind_t kind;
		logic fin;
		logic [CONN_W-1:0] conn;
		logic [31:0] now_tick;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [10:0] len;
	} cmd_t;

	localparam int QDEPTH = 2;

endpackage

>>> hw/rtl/trs_result_reg.sv
module trs_result_reg (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] in_action,
	input logic [2:0] in_conn,
	input logic [31:0] in_seq,
	input logic [31:0] in_ack,
	input logic [10:0] in_len,
	input logic in_last,
	output logic valid,
	input logic stall,
	output logic [2:0] action,
	output logic [2:0] out_connection,
	output logic [31:0] out_sequence,
	output logic [31:0] out_ack,
	output logic [10:0] out_length,
	output logic last
);
	import trs_pkg::*;

	logic valid_q;

	assign in_stall = valid_q && stall;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			action <= in_action;
			out_connection <= in_conn;
			out_sequence <= in_seq;
			out_ack <= in_ack;
			out_length <= in_len;
			last <= in_last;
		end
	end
endmodule

>>> hw/rtl/trs_front.sv
module trs_front (
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic stall,
	input logic [2:0] op,
	input logic [2:0] connection,
	input logic [31:0] now_tick,
	input logic [31:0] sequence_req,
	input logic [31:0] ack_value,
	input logic [10:0] segment_length,
	output logic q_valid,
	input logic q_pop,
	output trs_pkg::cmd_t q_cmd,
	output logic est_set,
	output logic [trs_pkg::CONN_W-1:0] est_conn,
	output logic rej_valid,
	input logic rej_stall,
	output logic [2:0] rej_action,
	output logic [2:0] rej_conn
);
	import trs_pkg::*;

	cmd_t q_mem [QDEPTH];
	logic [1:0] cnt_q;
	logic wp_q, rp_q;
	logic direct, push;
	cmd_t c;

	// establish and static rejects answer directly; the queue must be empty
	// so results stay in order; arm_data/ack checks that need slot state
	// are done in the back
	always_comb begin
		direct = 1'b1;
		rej_action = ACT_REJECTED;
		c.kind = CMD_TICK;
		c.fin = 1'b0;
		c.conn = connection;
		c.now_tick = now_tick;
		c.seq = sequence_req;
		c.ack = ack_value;
		c.len = segment_length;
		case (op)
			OP_TICK: begin
				direct = 1'b0;
			end
			OP_ARM_DATA: begin
				direct = 1'b0;
				c.kind = CMD_ARM;
			end
			OP_ARM_FIN: begin
				direct = 1'b0;
				c.kind = CMD_ARM;
				c.fin = 1'b1;
				c.len = 11'd1;
			end
			OP_ACK: begin
				direct = 1'b0;
				c.kind = CMD_ACK;
			end
			OP_ESTABLISH: rej_action = ACT_ACCEPTED;
			default: rej_action = ACT_REJECTED;
		endcase
	end

	assign stall = direct ? (rej_stall || cnt_q != 2'd0) : (cnt_q == 2'(QDEPTH));
	assign rej_valid = valid && direct && cnt_q == 2'd0;
	assign rej_conn = connection;
	assign push = valid && !stall && !direct;
	assign est_set = valid && !stall && direct && op == OP_ESTABLISH;
	assign est_conn = connection;

	assign q_valid = cnt_q != 2'd0;
	assign q_cmd = q_mem[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem[wp_q] <= c;
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'(QDEPTH) && !q_pop |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> cnt_q != 2'd0) else $error("queue underflow");
	a_direct_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rej_valid && !rej_stall |-> cnt_q == 2'd0) else $error("reorder");
`endif
endmodule

>>> hw/rtl/trs_back.sv
module trs_back (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [0:0] cfg_idx,
	input logic [15:0] cfg_data,
	input logic q_valid,
	output logic q_pop,
	input trs_pkg::cmd_t q_cmd,
	input logic est_set,
	input logic [trs_pkg::CONN_W-1:0] est_conn,
	output logic r_valid,
	input logic r_stall,
	output logic [2:0] r_action,
	output logic [2:0] r_conn,
	output logic [31:0] r_seq,
	output logic [31:0] r_ack,
	output logic [10:0] r_len,
	output logic r_last
);
	import trs_pkg::*;

	logic [15:0] base_q;
	logic [3:0] maxr_q;
	logic [CONNECTIONS-1:0] est_q, pend_q, fin_q;
	logic [31:0] seq_q [CONNECTIONS];
	logic [31:0] ack_q [CONNECTIONS];
	logic [10:0] len_q [CONNECTIONS];
	logic [31:0] start_q [CONNECTIONS];
	logic [TIMEOUT_W-1:0] to_q [CONNECTIONS];
	logic [3:0] retry_q [CONNECTIONS];
	logic [CONN_W:0] scan_q;
	logic [CONN_W-1:0] c;
	logic scanning, scan_end, exp, abort, ok, fire;
	logic [31:0] elapsed;
	logic [17:0] cap;
	logic [18:0] dbl;
	logic [32:0] need;

	assign scanning = q_valid && q_cmd.kind == CMD_TICK;
	assign scan_end = scan_q == (CONN_W+1)'(CONNECTIONS);
	assign c = scanning ? scan_q[CONN_W-1:0] : q_cmd.conn;
	assign elapsed = q_cmd.now_tick - start_q[c];
	assign exp = est_q[c] && pend_q[c] && elapsed >= 32'(to_q[c]);
	assign abort = retry_q[c] >= maxr_q;
	assign cap = {base_q, 2'b00};
	assign dbl = {to_q[c], 1'b0};
	assign need = 33'(seq_q[c]) + 33'(len_q[c]);

	always_comb begin
		ok = 1'b0;
		r_valid = 1'b0;
		r_action = ACT_REJECTED;
		r_conn = c;
		r_seq = '0;
		r_ack = '0;
		r_len = '0;
		r_last = 1'b1;
		q_pop = 1'b0;
		if (q_valid) begin
			case (q_cmd.kind)
				CMD_TICK: begin
					if (scan_end) begin
						r_valid = 1'b1;
						r_action = ACT_DONE;
						r_conn = '0;
						q_pop = !r_stall;
					end else if (exp) begin
						r_valid = 1'b1;
						r_last = 1'b0;
						if (abort) begin
							r_action = ACT_ABORTED;
						end else begin
							r_action = fin_q[c] ? ACT_RESEND_FIN : ACT_RESEND_DATA;
							r_seq = seq_q[c];
							r_ack = ack_q[c];
							r_len = fin_q[c] ? 11'd0 : len_q[c];
						end
					end
				end
				CMD_ARM: begin
					r_valid = 1'b1;
					ok = est_q[c] && (q_cmd.fin || (!pend_q[c] && q_cmd.len >= 11'd1
						&& q_cmd.len <= 11'(MAX_PAYLOAD)));
					r_action = ok ? ACT_ACCEPTED : ACT_REJECTED;
					q_pop = !r_stall;
				end
				CMD_ACK: begin
					r_valid = 1'b1;
					ok = est_q[c] && pend_q[c] && 33'(q_cmd.ack) >= need;
					r_action = !ok ? ACT_REJECTED : (fin_q[c] ? ACT_CLOSED : ACT_ACKED);
					q_pop = !r_stall;
				end
				default: r_valid = 1'b0;
			endcase
		end
	end

	assign fire = r_valid && !r_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_TIMEOUT_RESET;
			maxr_q <= MAX_RETRIES_RESET;
			est_q <= '0;
			pend_q <= '0;
			fin_q <= '0;
			scan_q <= '0;
		end else begin
			if (cfg_we && cfg_idx == REG_BASE_TIMEOUT) base_q <= cfg_data;
			if (cfg_we && cfg_idx == REG_MAX_RETRIES) maxr_q <= cfg_data[3:0];
			if (est_set) begin
				est_q[est_conn] <= 1'b1;
				pend_q[est_conn] <= 1'b0;
				fin_q[est_conn] <= 1'b0;
			end
			if (scanning) begin
				if (scan_end) begin
					if (fire) scan_q <= '0;
				end else if (!exp || fire) begin
					scan_q <= scan_q + (CONN_W+1)'(1);
					if (exp && abort) begin
						est_q[c] <= 1'b0;
						pend_q[c] <= 1'b0;
						fin_q[c] <= 1'b0;
					end
				end
			end else if (fire && ok && q_cmd.kind == CMD_ARM) begin
				pend_q[c] <= 1'b1;
				fin_q[c] <= q_cmd.fin;
			end else if (fire && ok && q_cmd.kind == CMD_ACK) begin
				pend_q[c] <= 1'b0;
				if (fin_q[c]) begin
					fin_q[c] <= 1'b0;
					est_q[c] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scanning && !scan_end && exp && fire && !abort) begin
			start_q[c] <= q_cmd.now_tick;
			if (to_q[c] < cap) to_q[c] <= dbl[18] ? TIMEOUT_MAX : dbl[17:0];
			if (retry_q[c] < RETRY_SAT) retry_q[c] <= retry_q[c] + 4'd1;
		end else if (!scanning && fire && ok && q_cmd.kind == CMD_ARM) begin
			seq_q[c] <= q_cmd.seq;
			ack_q[c] <= q_cmd.ack;
			len_q[c] <= q_cmd.len;
			start_q[c] <= q_cmd.now_tick;
			to_q[c] <= {2'b00, base_q};
			retry_q[c] <= '0;
		end else if (!scanning && fire && ok && q_cmd.kind == CMD_ACK) begin
			retry_q[c] <= '0;
		end
	end

`ifndef NO_ASSERTIONS
	a_pend_needs_est: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q & ~est_q) == '0) else $error("pending on closed slot");
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q <= (CONN_W+1)'(CONNECTIONS)) else $error("scan index");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_action == ACT_DONE |-> r_last) else $error("done not last");
`endif
endmodule

>>> hw/rtl/tcp_retransmit_supervisor.sv
// Supervises one outstanding segment on each of 8 connections. Non-tick
// transactions give one result; an arm or ack result passes through the
// command queue and the output register, an establish or a reject of a bad
// op through the output register only. A tick walks the slots one per cycle,
// holding on an expired slot while the output stalls, and ends with a done
// result. Write configuration only while idle.
module tcp_retransmit_supervisor (
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic stall,
	input logic [2:0] op,
	input logic [2:0] connection,
	input logic [31:0] now_tick,
	input logic [31:0] sequence_req,
	input logic [31:0] ack_value,
	input logic [10:0] segment_length,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [15:0] cfg_data,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] action,
	output logic [2:0] out_connection,
	output logic [31:0] out_sequence,
	output logic [31:0] out_ack,
	output logic [10:0] out_length,
	output logic last
);
	import trs_pkg::*;

	logic q_valid, q_pop;
	cmd_t q_cmd;
	logic est_set;
	logic [CONN_W-1:0] est_conn;
	logic rej_valid;
	logic [2:0] rej_action, rej_conn;
	logic b_valid, b_last, o_stall;
	logic [2:0] b_action, b_conn;
	logic [31:0] b_seq, b_ack;
	logic [10:0] b_len;
	logic m_valid;

	trs_front u_front (
		.clk, .arst_n, .valid, .stall, .op, .connection, .now_tick,
		.sequence_req, .ack_value, .segment_length,
		.q_valid, .q_pop, .q_cmd, .est_set, .est_conn,
		.rej_valid, .rej_stall(o_stall), .rej_action, .rej_conn
	);

	trs_back u_back (
		.clk, .arst_n, .cfg_we, .cfg_idx(cfg_index), .cfg_data,
		.q_valid, .q_pop, .q_cmd, .est_set, .est_conn,
		.r_valid(b_valid), .r_stall(o_stall), .r_action(b_action),
		.r_conn(b_conn), .r_seq(b_seq), .r_ack(b_ack), .r_len(b_len),
		.r_last(b_last)
	);

	assign m_valid = b_valid || rej_valid;

	trs_result_reg u_out (
		.clk, .arst_n, .in_valid(m_valid), .in_stall(o_stall),
		.in_action(b_valid ? b_action : rej_action),
		.in_conn(b_valid ? b_conn : rej_conn),
		.in_seq(b_valid ? b_seq : 32'd0),
		.in_ack(b_valid ? b_ack : 32'd0),
		.in_len(b_valid ? b_len : 11'd0),
		.in_last(b_valid ? b_last : 1'b1),
		.valid(out_valid), .stall(out_stall), .action, .out_connection,
		.out_sequence, .out_ack, .out_length, .last
	);
endmodule
